// ===== src/bpc_pkg.sv =====
// shared types and constants for the barometric pressure compensation pipeline
package bpc_pkg;

  localparam int DataW   = 32;
  localparam int NumRegs = 5;
  localparam int AddrW   = 5;

  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;

  localparam logic [31:0] TempOffset  = 32'd4000;
  localparam logic [31:0] PressScale  = 32'd50000;
  localparam logic [31:0] B4Bias      = 32'd32768;
  localparam logic [31:0] PolyC1      = 32'd3038;
  localparam logic [31:0] PolyC2      = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PolyC3      = 32'd3791;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam logic [17:0] PressMax    = 18'h3FFFF;

  // coefficients, already extended to 32 bits
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } coef_t;

  // carried alongside the temperature divide
  typedef struct packed {
    logic [31:0] x1;
    logic        neg;
    logic        err;
    logic [15:0] up;
  } tdiv_side_t;

  // carried alongside the pressure divide
  typedef struct packed {
    logic [15:0] temp;
    logic        err;
    logic        dbl;
  } pdiv_side_t;

  function automatic logic [31:0] sext16(logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== src/bpc_regs.sv =====
// apb register file holding the packed calibration coefficients
module bpc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bpc_pkg::coef_t      coef
);
  import bpc_pkg::*;

  logic [31:0] regs [NumRegs];
  logic [2:0]  idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegAc1Ac2: regs[0] <= pwdata;
        RegAc3Ac4: regs[1] <= pwdata;
        RegAc5Ac6: regs[2] <= pwdata;
        RegB1B2:   regs[3] <= pwdata;
        RegMcMd:   regs[4] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAc1Ac2: prdata = regs[0];
      RegAc3Ac4: prdata = regs[1];
      RegAc5Ac6: prdata = regs[2];
      RegB1B2:   prdata = regs[3];
      RegMcMd:   prdata = regs[4];
      default:   prdata = '0;
    endcase
  end

  assign coef.ac1 = sext16(regs[0][31:16]);
  assign coef.ac2 = sext16(regs[0][15:0]);
  assign coef.ac3 = sext16(regs[1][31:16]);
  assign coef.ac4 = {16'b0, regs[1][15:0]};
  assign coef.ac5 = {16'b0, regs[2][31:16]};
  assign coef.ac6 = {16'b0, regs[2][15:0]};
  assign coef.b1  = sext16(regs[3][31:16]);
  assign coef.b2  = sext16(regs[3][15:0]);
  assign coef.mc  = sext16(regs[4][31:16]);
  assign coef.md  = sext16(regs[4][15:0]);

endmodule

// ===== src/bpc_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module bpc_div #(
  parameter int W      = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [W-1:0]      quotient,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [W];
  logic [W-1:0]      rem  [W];
  logic [W-1:0]      quo  [W];
  logic [W-1:0]      dvs  [W];
  logic [SIDE_W-1:0] side [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic              p_vld;
    logic [W-1:0]      p_rem, p_quo, p_dvs;
    logic [SIDE_W-1:0] p_side;
    logic [W:0]        sh, diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_quo  = dividend;
      assign p_dvs  = divisor;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_rem  = rem[i-1];
      assign p_quo  = quo[i-1];
      assign p_dvs  = dvs[i-1];
      assign p_side = side[i-1];
    end

    // dividend bits leave the top of quo while quotient bits enter at the bottom
    assign sh   = {p_rem, p_quo[W-1]};
    assign diff = sh - {1'b0, p_dvs};
    assign ge   = !diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? diff[W-1:0] : sh[W-1:0];
        quo[i]  <= {p_quo[W-2:0], ge};
        dvs[i]  <= p_dvs;
        side[i] <= p_side;
      end
    end
  end

  assign out_vld  = vld[W-1];
  assign quotient = quo[W-1];
  assign out_side = side[W-1];

endmodule

// ===== src/barometric_pressure_compensation_unit.sv =====
// top level: config registers, compensation pipeline and the two dividers
//
// Usage: raw_temperature and raw_pressure enter on a valid/ready channel; one
// result (temperature_deci_c, pressure_pa, divide_error) leaves per item on a
// second valid/ready channel. Coefficients must be written over the APB port
// only while idle, which the block does not enforce; reads give stored words.
// From input accept to output valid an item passes two front stages, a
// 32-stage temperature divider, six arithmetic stages, a 32-stage pressure
// divider and three back stages ending in the output register.
// Throughput is one item per cycle unless the output stalls. The dividers set
// the depth at one bit per stage; each stage holds at most three multipliers.
// The whole pipeline advances together: when the output holds a result that
// is not taken, every stage freezes and in_ready drops, so nothing is lost
// or repeated. Bubbles inside the pipeline are not squeezed out.
// Reset clears all valid bits and the coefficient registers to zero.
// A zero divisor in either divide gives divide_error with zero results.
module barometric_pressure_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_temperature,
  input  logic [15:0] raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] temperature_deci_c,
  output logic [17:0] pressure_pa,
  output logic        divide_error
);
  import bpc_pkg::*;

  coef_t c;
  logic  en;

  bpc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .coef(c)
  );

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: first temperature product
  logic        v1;
  logic [31:0] prod1;
  logic [15:0] up1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ({16'b0, raw_temperature} - c.ac6) * c.ac5;
      up1   <= raw_pressure;
    end
  end

  // stage 2: divisor and dividend magnitudes
  logic        v2;
  logic [31:0] x1_s1, den_s1, num_s1, ma2, mb2;
  tdiv_side_t  ts2;
  assign x1_s1  = 32'($signed(prod1) >>> 15);
  assign den_s1 = x1_s1 + c.md;
  assign num_s1 = c.mc << 11;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ma2     <= num_s1[31] ? 32'(0) - num_s1 : num_s1;
      mb2     <= den_s1[31] ? 32'(0) - den_s1 : den_s1;
      ts2.x1  <= x1_s1;
      ts2.neg <= num_s1[31] ^ den_s1[31];
      ts2.err <= (den_s1 == '0);
      ts2.up  <= up1;
    end
  end

  logic        vd1;
  logic [31:0] q1;
  logic [$bits(tdiv_side_t)-1:0] sd1_raw;
  tdiv_side_t  sd1;
  bpc_div #(.W(DataW), .SIDE_W($bits(tdiv_side_t))) u_tdiv (
    .clk, .rst, .en, .in_vld(v2), .dividend(ma2), .divisor(mb2),
    .in_side(ts2), .out_vld(vd1), .quotient(q1), .out_side(sd1_raw)
  );
  assign sd1 = tdiv_side_t'(sd1_raw);

  // stage 3: b5, temperature, b6
  logic        v3, err3;
  logic [31:0] x2_3, b5_3, t_3, b6;
  logic [15:0] temp3, up3;
  logic [15:0] tsat;
  assign x2_3 = sd1.neg ? 32'(0) - q1 : q1;
  assign b5_3 = sd1.x1 + x2_3;
  assign t_3  = 32'($signed(b5_3 + 32'd8) >>> 4);
  always_comb begin
    if ($signed(t_3) > 32'sd32767)       tsat = 16'h7FFF;
    else if ($signed(t_3) < -32'sd32768) tsat = 16'h8000;
    else                                 tsat = t_3[15:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= vd1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b6    <= b5_3 - TempOffset;
      temp3 <= tsat;
      err3  <= sd1.err;
      up3   <= sd1.up;
    end
  end

  // stage 4: products of b6
  logic        v4, err4;
  logic [31:0] sq4, mac2, mac3;
  logic [15:0] temp4, up4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq4   <= b6 * b6;
      mac2  <= c.ac2 * b6;
      mac3  <= c.ac3 * b6;
      temp4 <= temp3;
      err4  <= err3;
      up4   <= up3;
    end
  end

  // stage 5: second-order products
  logic        v5, err5;
  logic [31:0] t1_5, mb1_5, x2a5, x1c5;
  logic [15:0] temp5, up5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t1_5  <= c.b2 * sq4;
      mb1_5 <= c.b1 * 32'($signed(sq4) >>> 12);
      x2a5  <= 32'($signed(mac2) >>> 11);
      x1c5  <= 32'($signed(mac3) >>> 13);
      temp5 <= temp4;
      err5  <= err4;
      up5   <= up4;
    end
  end

  // stage 6: b3 and x3
  logic        v6, err6;
  logic [31:0] x1_6, x3_6, x2c_6, b3, x3c;
  logic [15:0] temp6, up6;
  assign x1_6  = 32'($signed(32'($signed(t1_5) >>> 12)) >>> 11);
  assign x3_6  = x1_6 + x2a5;
  assign x2c_6 = 32'($signed(mb1_5) >>> 16);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3    <= 32'($signed((c.ac1 << 2) + x3_6 + 32'd2) >>> 2);
      x3c   <= 32'($signed(x1c5 + x2c_6 + 32'd2) >>> 2);
      temp6 <= temp5;
      err6  <= err5;
      up6   <= up5;
    end
  end

  // stage 7: b4 and b7 products
  logic        v7, err7;
  logic [31:0] b4p, b7;
  logic [15:0] temp7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4p   <= c.ac4 * (x3c + B4Bias);
      b7    <= ({16'b0, up6} - b3) * PressScale;
      temp7 <= temp6;
      err7  <= err6;
    end
  end

  // stage 8: divider operands, the top bit of b7 picks the branch
  logic        v8;
  logic [31:0] b4_7, dvd8, dvs8;
  pdiv_side_t  ps8;
  assign b4_7 = b4p >> 15;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dvd8     <= (b7 < SignBit) ? (b7 << 1) : b7;
      dvs8     <= b4_7;
      ps8.temp <= temp7;
      ps8.err  <= err7 || (b4_7 == '0);
      ps8.dbl  <= !(b7 < SignBit);
    end
  end

  logic        vd2;
  logic [31:0] q2;
  logic [$bits(pdiv_side_t)-1:0] sd2_raw;
  pdiv_side_t  sd2;
  bpc_div #(.W(DataW), .SIDE_W($bits(pdiv_side_t))) u_pdiv (
    .clk, .rst, .en, .in_vld(v8), .dividend(dvd8), .divisor(dvs8),
    .in_side(ps8), .out_vld(vd2), .quotient(q2), .out_side(sd2_raw)
  );
  assign sd2 = pdiv_side_t'(sd2_raw);

  // stage 9: p and its first products
  logic        v9, err9;
  logic [31:0] p_8, a8, p9, sq9, x2m9;
  logic [15:0] temp9;
  assign p_8 = sd2.dbl ? (q2 << 1) : q2;
  assign a8  = 32'($signed(p_8) >>> 8);
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= vd2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p9    <= p_8;
      sq9   <= a8 * a8;
      x2m9  <= PolyC2 * p_8;
      temp9 <= sd2.temp;
      err9  <= sd2.err;
    end
  end

  // stage 10: scale the square term
  logic        v10, err10;
  logic [31:0] p10, x1m10, x2m10;
  logic [15:0] temp10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p10    <= p9;
      x1m10  <= sq9 * PolyC1;
      x2m10  <= x2m9;
      temp10 <= temp9;
      err10  <= err9;
    end
  end

  // stage 11: final correction, saturation, output register
  logic [31:0] sum10, pr10;
  logic [17:0] psat;
  assign sum10 = 32'($signed(x1m10) >>> 16) + 32'($signed(x2m10) >>> 16) + PolyC3;
  assign pr10  = p10 + 32'($signed(sum10) >>> 4);
  always_comb begin
    if (pr10[31])                    psat = '0;
    else if (pr10 > {14'b0, PressMax}) psat = PressMax;
    else                             psat = pr10[17:0];
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temperature_deci_c <= err10 ? '0 : temp10;
      pressure_pa        <= err10 ? '0 : psat;
      divide_error       <= err10;
    end
  end

endmodule

// ===== src/bpc_checker.sv =====
// port-level checks for the compensation unit, bound to the top level
module bpc_assert (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] temperature_deci_c,
  input logic [17:0] pressure_pa,
  input logic        divide_error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa)
      && $stable(temperature_deci_c))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> temperature_deci_c == '0 && pressure_pa == '0)
    else $error("error item carries nonzero results");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind barometric_pressure_compensation_unit bpc_assert u_bpc_assert (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .temperature_deci_c, .pressure_pa, .divide_error
);
